// ===== sv/fbdr_pkg.sv =====
// shared types and codes for the page framebuffer with dirty-box refresh
// no dependencies; imported by every module of the block
package fbdr_pkg;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;
	localparam logic [1:0] CMD_REFRESH = 2'd3;

	localparam logic [2:0] KIND_ACK      = 3'd0;
	localparam logic [2:0] KIND_READ     = 3'd1;
	localparam logic [2:0] KIND_POSITION = 3'd2;
	localparam logic [2:0] KIND_DATA     = 3'd3;
	localparam logic [2:0] KIND_NONE     = 3'd4;

	localparam logic [1:0] PHASE_IDLE     = 2'd0;
	localparam logic [1:0] PHASE_POSITION = 2'd1;
	localparam logic [1:0] PHASE_DATA     = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic       color;
	} fbdr_req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] page;
		logic [6:0] column;
		logic [7:0] data_byte;
		logic       pixel;
		logic       last;
	} fbdr_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic clr_step;
	} fbdr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic clr_last;
	} fbdr_sts_t;

endpackage

// ===== sv/fbdr_ctrl.sv =====
// controller state machine: accept, execute, clearing sweep
// depends on fbdr_pkg
module fbdr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic              out_free,
	input  fbdr_pkg::fbdr_sts_t sts,
	output fbdr_pkg::fbdr_cmd_t ctl
);
	import fbdr_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		ctl.capture  = 1'b0;
		ctl.execute  = 1'b0;
		ctl.clr_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					ctl.execute = 1'b1;
					state_d     = sts.is_clear ? ST_CLEAR : ST_IDLE;
				end
			end
			ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// reset starts with a sweep that zeroes the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/fbdr_dp.sv =====
// datapath: frame store memory, dirty box, refresh walk and result forming
// depends on fbdr_pkg
module fbdr_dp #(
	parameter int WIDTH_COLUMNS = 128,
	parameter int PAGE_COUNT    = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fbdr_pkg::fbdr_req_t req,
	input  fbdr_pkg::fbdr_cmd_t ctl,
	output fbdr_pkg::fbdr_sts_t sts,
	output fbdr_pkg::fbdr_rsp_t rsp
);
	import fbdr_pkg::*;

	localparam int STORE_SIZE = WIDTH_COLUMNS * PAGE_COUNT;
	localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int CW = $clog2(WIDTH_COLUMNS);
	localparam int AW = $clog2(STORE_SIZE);
	localparam logic [8:0] X_LIM = 9'(WIDTH_COLUMNS);
	localparam logic [8:0] Y_LIM = 9'(PAGE_COUNT * 8);
	localparam logic [PW-1:0] PAGE_MAX = PW'(PAGE_COUNT - 1);
	localparam logic [CW-1:0] COL_MAX  = CW'(WIDTH_COLUMNS - 1);
	localparam logic [AW-1:0] ADDR_MAX = AW'(STORE_SIZE - 1);

	logic [7:0] mem [STORE_SIZE];

	// captured transaction
	logic [1:0]    cmd_q;
	logic          color_q;
	logic          inside_q;
	logic [PW-1:0] pg_q;
	logic [CW-1:0] col_q;
	logic [2:0]    bit_q;
	logic [AW-1:0] addr_q;
	logic [7:0]    rd_q;

	// dirty box and walk
	logic [PW-1:0] first_pg_q, last_pg_q, walk_pg_q;
	logic [CW-1:0] first_col_q, last_col_q, walk_col_q;
	logic          empty_q;
	logic [1:0]    phase_q;
	logic [AW-1:0] clr_cnt_q;

	logic          req_inside;
	logic [PW-1:0] req_pg;
	logic [CW-1:0] req_col;
	logic [AW-1:0] pix_addr, walk_addr, rd_addr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata, mask;
	logic          col_end, pg_end;

	assign req_inside = ({1'b0, req.pos_x} < X_LIM) && ({1'b0, req.pos_y} < Y_LIM);
	assign req_pg     = req.pos_y[3 +: PW];
	assign req_col    = req.pos_x[CW-1:0];
	assign pix_addr   = AW'(req_pg) * AW'(WIDTH_COLUMNS) + AW'(req_col);
	assign walk_addr  = AW'(walk_pg_q) * AW'(WIDTH_COLUMNS) + AW'(walk_col_q);
	assign rd_addr    = (req.command == CMD_REFRESH) ? walk_addr : pix_addr;

	assign mask  = 8'b1 << bit_q;
	assign we    = ctl.clr_step || (ctl.execute && cmd_q == CMD_WRITE && inside_q);
	assign waddr = ctl.clr_step ? clr_cnt_q : addr_q;
	assign wdata = ctl.clr_step ? 8'h00 : (color_q ? (rd_q | mask) : (rd_q & ~mask));

	assign col_end = (walk_col_q >= last_col_q);
	assign pg_end  = (walk_pg_q >= last_pg_q);

	assign sts.is_clear = (cmd_q == CMD_CLEAR);
	assign sts.clr_last = (clr_cnt_q == ADDR_MAX);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.capture) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= req.command;
			color_q  <= req.color;
			inside_q <= req_inside;
			pg_q     <= req_pg;
			col_q    <= req_col;
			bit_q    <= req.pos_y[2:0];
			addr_q   <= pix_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pg_q  <= '0;
			last_pg_q   <= PAGE_MAX;
			first_col_q <= '0;
			last_col_q  <= COL_MAX;
			empty_q     <= 1'b0;
			walk_pg_q   <= '0;
			walk_col_q  <= '0;
			phase_q     <= PHASE_IDLE;
			clr_cnt_q   <= '0;
		end else begin
			if (ctl.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (ctl.execute) begin
				case (cmd_q)
					CMD_WRITE: begin
						if (inside_q) begin
							if (empty_q) begin
								first_pg_q  <= pg_q;
								last_pg_q   <= pg_q;
								first_col_q <= col_q;
								last_col_q  <= col_q;
								empty_q     <= 1'b0;
							end else begin
								if (pg_q < first_pg_q)   first_pg_q  <= pg_q;
								if (pg_q > last_pg_q)    last_pg_q   <= pg_q;
								if (col_q < first_col_q) first_col_q <= col_q;
								if (col_q > last_col_q)  last_col_q  <= col_q;
							end
						end
					end
					CMD_CLEAR: begin
						first_pg_q  <= '0;
						last_pg_q   <= PAGE_MAX;
						first_col_q <= '0;
						last_col_q  <= COL_MAX;
						empty_q     <= 1'b0;
						phase_q     <= PHASE_IDLE;
						clr_cnt_q   <= '0;
					end
					CMD_REFRESH: begin
						case (phase_q)
							PHASE_IDLE: begin
								if (!empty_q) begin
									walk_pg_q  <= first_pg_q;
									walk_col_q <= first_col_q;
									phase_q    <= PHASE_DATA;
								end
							end
							PHASE_POSITION: begin
								walk_col_q <= first_col_q;
								phase_q    <= PHASE_DATA;
							end
							PHASE_DATA: begin
								if (col_end) begin
									if (pg_end) begin
										phase_q <= PHASE_IDLE;
										empty_q <= 1'b1;
									end else begin
										walk_pg_q <= walk_pg_q + 1'b1;
										phase_q   <= PHASE_POSITION;
									end
								end else begin
									walk_col_q <= walk_col_q + 1'b1;
								end
							end
							default: begin
								phase_q <= PHASE_IDLE;
							end
						endcase
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result of the captured transaction
	always_comb begin
		rsp = '0;
		case (cmd_q)
			CMD_READ: begin
				rsp.kind  = KIND_READ;
				rsp.pixel = inside_q & rd_q[bit_q];
			end
			CMD_REFRESH: begin
				case (phase_q)
					PHASE_IDLE: begin
						if (empty_q) begin
							rsp.kind = KIND_NONE;
							rsp.last = 1'b1;
						end else begin
							rsp.kind   = KIND_POSITION;
							rsp.page   = 3'(first_pg_q);
							rsp.column = 7'(first_col_q);
						end
					end
					PHASE_POSITION: begin
						rsp.kind   = KIND_POSITION;
						rsp.page   = 3'(walk_pg_q);
						rsp.column = 7'(first_col_q);
					end
					PHASE_DATA: begin
						rsp.kind      = KIND_DATA;
						rsp.page      = 3'(walk_pg_q);
						rsp.column    = 7'(walk_col_q);
						rsp.data_byte = rd_q;
						rsp.last      = col_end & pg_end;
					end
					default: begin
						rsp.kind = KIND_ACK;
					end
				endcase
			end
			default: begin
				rsp.kind = KIND_ACK;
			end
		endcase
	end

endmodule

// ===== sv/page_framebuffer_dirty_refresh_top.sv =====
// top level of the page framebuffer with dirty-box refresh
// depends on fbdr_pkg, fbdr_ctrl, fbdr_dp
//
//  channel | signals                          | moves
//  --------+----------------------------------+-----------------------------------
//  cmd     | cmd_valid, cmd_ready, cmd_data   | one command transaction in
//  rsp     | rsp_valid, rsp_ready, rsp_data   | one result transaction out
//
// write, read and refresh run as a registered read of the frame store,
// then the modify-write of that byte and the result
// clear runs a sweep of the whole store, one byte per cycle
// after reset the same sweep runs with cmd_ready low
// a command is taken while the previous result still sits in the result register;
// the execute cycle waits only while that register is full and not being drained
module page_framebuffer_dirty_refresh_top #(
	parameter int WIDTH_COLUMNS = 128,
	parameter int PAGE_COUNT    = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  fbdr_pkg::fbdr_req_t cmd_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output fbdr_pkg::fbdr_rsp_t rsp_data
);
	import fbdr_pkg::*;

	fbdr_cmd_t ctl;
	fbdr_sts_t sts;
	fbdr_rsp_t result;
	logic      out_free;
	logic      rsp_valid_q;
	fbdr_rsp_t rsp_q;

	// result register is free when empty or handing over this cycle
	assign out_free = !rsp_valid_q || rsp_ready;

	fbdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.out_free (out_free),
		.sts      (sts),
		.ctl      (ctl)
	);

	fbdr_dp #(
		.WIDTH_COLUMNS(WIDTH_COLUMNS),
		.PAGE_COUNT   (PAGE_COUNT)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (cmd_data),
		.ctl   (ctl),
		.sts   (sts),
		.rsp   (result)
	);

	// result register, loaded on the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.execute) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// no command is taken while the clearing sweep runs
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_step |-> !cmd_ready)
		else $error("command accepted during clearing sweep");

	// one transaction at a time: after an accept the port closes
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("second command accepted before the first executed");

	// a result is only produced into a free result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.execute |-> (!rsp_valid || rsp_ready))
		else $error("result register overwritten");

	// last only closes a refresh run
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.last) |-> (rsp_data.kind == KIND_DATA ||
			rsp_data.kind == KIND_NONE))
		else $error("last flag on a non-refresh result");

endmodule

// ===== test/page_framebuffer_dirty_refresh_top_tb.sv =====
// self-checking testbench for the page framebuffer with dirty-box refresh
// depends on fbdr_pkg and page_framebuffer_dirty_refresh_top; the scoreboard lives in this file
`timescale 1ns / 1ps

module page_framebuffer_dirty_refresh_top_tb;

	import fbdr_pkg::*;

	localparam int COLUMNS        = 128;
	localparam int PAGES          = 8;
	localparam int ROWS           = PAGES * 8;
	// cycles with no transaction on either channel before the run is declared hung;
	// the slowest correct gap is the reset sweep or a clear sweep plus stalls
	localparam int WATCHDOG_LIMIT = 8000;
	// command transactions over the whole run, directed part included
	localparam int TOTAL_ITEMS    = 1700;

	// software copy of the frame store, the dirty box and the refresh walk;
	// every accepted command transaction is applied here and its result queued
	class framebuffer_mirror;
		logic [7:0] frame [COLUMNS*PAGES];
		logic [2:0] box_first_page, box_last_page;
		logic [6:0] box_first_col, box_last_col;
		bit         box_empty;
		logic [2:0] walk_pg;
		logic [6:0] walk_col;
		logic [1:0] walk_state;
		fbdr_rsp_t  awaited[$];
		int         failures;

		function new();
			wipe();
			walk_pg  = '0;
			walk_col = '0;
			failures = 0;
		endfunction

		// zeroed store, full-screen box, no walk in progress
		function void wipe();
			foreach (frame[i])
				frame[i] = 8'h00;
			box_first_page = '0;
			box_last_page  = 3'(PAGES - 1);
			box_first_col  = '0;
			box_last_col   = 7'(COLUMNS - 1);
			box_empty      = 1'b0;
			walk_state     = PHASE_IDLE;
		endfunction

		function void apply_command(fbdr_req_t req);
			fbdr_rsp_t  r;
			bit         in_range;
			logic [2:0] pg;
			logic [6:0] col;
			int         idx;
			r        = '0;
			in_range = (req.pos_x < COLUMNS) && (req.pos_y < ROWS);
			pg       = req.pos_y[5:3];
			col      = req.pos_x[6:0];
			idx      = pg * COLUMNS + col;
			case (req.command)
				CMD_WRITE: begin
					r.kind = KIND_ACK;
					if (in_range) begin
						if (box_empty) begin
							box_first_page = pg;
							box_last_page  = pg;
							box_first_col  = col;
							box_last_col   = col;
							box_empty      = 1'b0;
						end else begin
							if (pg < box_first_page) box_first_page = pg;
							if (pg > box_last_page) box_last_page = pg;
							if (col < box_first_col) box_first_col = col;
							if (col > box_last_col) box_last_col = col;
						end
						frame[idx][req.pos_y[2:0]] = req.color;
					end
				end
				CMD_READ: begin
					r.kind = KIND_READ;
					if (in_range)
						r.pixel = frame[idx][req.pos_y[2:0]];
				end
				CMD_CLEAR: begin
					r.kind = KIND_ACK;
					wipe();
				end
				default: begin
					r.kind = KIND_ACK;
					if (walk_state == PHASE_IDLE) begin
						if (box_empty) begin
							r.kind = KIND_NONE;
							r.last = 1'b1;
						end else begin
							walk_pg    = box_first_page;
							walk_state = PHASE_POSITION;
						end
					end
					if (walk_state == PHASE_POSITION) begin
						r.kind     = KIND_POSITION;
						r.page     = walk_pg;
						r.column   = box_first_col;
						walk_col   = box_first_col;
						walk_state = PHASE_DATA;
					end else if (walk_state == PHASE_DATA) begin
						r.kind      = KIND_DATA;
						r.page      = walk_pg;
						r.column    = walk_col;
						r.data_byte = frame[walk_pg * COLUMNS + walk_col];
						if (walk_col >= box_last_col) begin
							if (walk_pg >= box_last_page) begin
								r.last     = 1'b1;
								walk_state = PHASE_IDLE;
								box_empty  = 1'b1;
							end else begin
								walk_pg    = walk_pg + 3'd1;
								walk_state = PHASE_POSITION;
							end
						end else begin
							walk_col = walk_col + 7'd1;
						end
					end
				end
			endcase
			awaited.push_back(r);
		endfunction

		function void check_field(string label, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t mismatch %s expected %0d actual %0d", $time, label, want, got);
				failures++;
			end
		endfunction

		function void compare_result(fbdr_rsp_t got);
			fbdr_rsp_t want;
			if (awaited.size() == 0) begin
				$display("%0t unexpected result expected none actual %h", $time, got);
				failures++;
				return;
			end
			want = awaited.pop_front();
			check_field("kind", 32'(want.kind), 32'(got.kind));
			check_field("page", 32'(want.page), 32'(got.page));
			check_field("column", 32'(want.column), 32'(got.column));
			check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
			check_field("pixel", 32'(want.pixel), 32'(got.pixel));
			check_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	fbdr_req_t cmd_data;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	fbdr_rsp_t rsp_data;

	framebuffer_mirror mirror;
	// random idling on both channels; cleared for stretches and for the tail of the run
	bit idle_on;
	int sent;
	int stall_left = 0;

	page_framebuffer_dirty_refresh_top #(
		.WIDTH_COLUMNS(COLUMNS),
		.PAGE_COUNT(PAGES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_data(cmd_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic fbdr_req_t make_req(logic [1:0] c, logic [7:0] x, logic [7:0] y,
		logic color);
		fbdr_req_t q;
		q.command = c;
		q.pos_x   = x;
		q.pos_y   = y;
		q.color   = color;
		return q;
	endfunction

	// in-range pixel write inside a small window, so refresh walks stay short
	function automatic fbdr_req_t region_write(int base_col, int base_page);
		return make_req(CMD_WRITE, 8'(base_col + $urandom_range(0, 7)),
			8'(base_page * 8 + $urandom_range(0, 15)), $urandom_range(0, 3) != 0);
	endfunction

	function automatic fbdr_req_t region_read(int base_col, int base_page);
		return make_req(CMD_READ, 8'(base_col + $urandom_range(0, 7)),
			8'(base_page * 8 + $urandom_range(0, 15)), 1'($urandom_range(0, 1)));
	endfunction

	// one command transaction; valid stays high afterwards so a following call
	// keeps the channel busy, unless a gap lowers it first
	task automatic send_command(input fbdr_req_t req);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= req;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		// accepted at this edge: apply to the mirror right away so the walk state is current
		mirror.apply_command(req);
		sent++;
	endtask

	// hold the sender until every queued result has been drained
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (mirror.awaited.size() != 0)
			@(posedge clk);
	endtask

	// refresh steps until the walk ends; with an empty box this is a single nothing-dirty step.
	// writes into the window may be mixed in, which can grow the box under the running walk
	task automatic refresh_to_end(int write_pct, int base_col, int base_page);
		do begin
			send_command(make_req(CMD_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom)));
			if ($urandom_range(0, 99) < write_pct)
				send_command(region_write(base_col, base_page));
		end while (mirror.walk_state != PHASE_IDLE);
	endtask

	// result side: random stall bursts with rsp_ready low, one assignment per edge
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 4) - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// every result transaction is checked against the oldest queued expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			mirror.compare_result(rsp_data);
	end

	// hang detection: no transaction on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int random_goal;
		int idle_cutoff;
		int choice;
		int base_col;
		int base_page;
		int n;
		mirror     = new();
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		cmd_data   = '0;
		idle_on    = 1'b1;
		sent       = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corner pixels, color clear, out-of-range writes and reads
		send_command(make_req(CMD_WRITE, 8'd0, 8'd0, 1'b1));
		send_command(make_req(CMD_WRITE, 8'd127, 8'd63, 1'b1));
		send_command(make_req(CMD_WRITE, 8'd127, 8'd0, 1'b1));
		send_command(make_req(CMD_WRITE, 8'd127, 8'd0, 1'b0));
		send_command(make_req(CMD_WRITE, 8'd0, 8'd63, 1'b1));
		send_command(make_req(CMD_WRITE, 8'd128, 8'd0, 1'b1));
		send_command(make_req(CMD_WRITE, 8'd0, 8'd64, 1'b1));
		send_command(make_req(CMD_WRITE, 8'd255, 8'd255, 1'b1));
		send_command(make_req(CMD_READ, 8'd0, 8'd0, 1'b0));
		send_command(make_req(CMD_READ, 8'd127, 8'd63, 1'b1));
		send_command(make_req(CMD_READ, 8'd127, 8'd0, 1'b0));
		send_command(make_req(CMD_READ, 8'd0, 8'd63, 1'b1));
		send_command(make_req(CMD_READ, 8'd128, 8'd0, 1'b0));
		send_command(make_req(CMD_READ, 8'd0, 8'd64, 1'b1));
		send_command(make_req(CMD_READ, 8'd255, 8'd255, 1'b1));
		// start the full-screen walk, then clear in the middle of it
		send_command(make_req(CMD_REFRESH, 8'd0, 8'd0, 1'b0));
		send_command(make_req(CMD_REFRESH, 8'd255, 8'd255, 1'b1));
		send_command(make_req(CMD_CLEAR, 8'd0, 8'd0, 1'b0));
		send_command(make_req(CMD_READ, 8'd0, 8'd0, 1'b0));
		send_command(make_req(CMD_WRITE, 8'd127, 8'd63, 1'b1));
		send_command(make_req(CMD_READ, 8'd127, 8'd63, 1'b0));
		// sender holds off until the block has answered everything
		drain_results();
		// full-screen walk after clear, then refresh of an empty box
		refresh_to_end(0, 0, 0);
		refresh_to_end(0, 0, 0);
		// write to an empty box: box shrinks to exactly that pixel's page and column
		send_command(make_req(CMD_WRITE, 8'd5, 8'd10, 1'b1));
		refresh_to_end(0, 0, 0);

		// random part: mostly write bursts followed by a complete walk
		random_goal = TOTAL_ITEMS;
		idle_cutoff = (TOTAL_ITEMS * 85) / 100;
		while (sent < random_goal) begin
			idle_on = (sent < idle_cutoff) ? ($urandom_range(0, 4) != 0) : 1'b0;
			choice  = $urandom_range(0, 99);
			if (choice < 65) begin
				base_col  = $urandom_range(0, 120);
				base_page = $urandom_range(0, 6);
				n         = $urandom_range(1, 6);
				repeat (n) send_command(region_write(base_col, base_page));
				repeat ($urandom_range(0, 2)) send_command(region_read(base_col, base_page));
				refresh_to_end(10, base_col, base_page);
				send_command(region_read(base_col, base_page));
			end else if (choice < 85) begin
				// noise: reads anywhere, writes that fall outside the screen
				n = $urandom_range(1, 6);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0: send_command(make_req(CMD_READ, 8'($urandom), 8'($urandom),
							1'($urandom)));
						1: send_command(make_req(CMD_WRITE, 8'($urandom),
							8'($urandom_range(ROWS, 255)), 1'($urandom)));
						default: send_command(make_req(CMD_WRITE,
							8'($urandom_range(COLUMNS, 255)), 8'($urandom), 1'($urandom)));
					endcase
				end
			end else if (choice < 93) begin
				refresh_to_end(0, 0, 0);
			end else begin
				drain_results();
				send_command(make_req(CMD_READ, 8'($urandom_range(0, COLUMNS - 1)),
					8'($urandom_range(0, ROWS - 1)), 1'($urandom)));
			end
		end
		cmd_valid <= 1'b0;

		while (mirror.awaited.size() != 0)
			@(posedge clk);
		// a few more cycles to catch a spurious late result
		repeat (20) @(posedge clk);
		if (mirror.failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
